### rtl/asa_pkg.sv
// Shared types and constants for the aligned stack allocator.
// Operation and status codes, register indexes, mark and result records.
// No dependencies.
package asa_pkg;

    localparam int HEADER_BYTES_DEF = 16;
    localparam int MAX_BLOCKS_DEF   = 256;

    localparam int ADDR_W = 32;
    localparam int ADJ_W  = 8;
    localparam int LIVE_W = 9;
    localparam int LG_W   = 3;

    // Register indexes on the configuration port
    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_POOL_SIZE = 1'b1;

    localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'd0;
    localparam logic [ADDR_W-1:0] POOL_SIZE_RST = 32'd65536;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // One mark: previous newest block address and the adjustment used
    typedef struct packed {
        logic [ADDR_W-1:0] prev;
        logic [ADJ_W-1:0]  adj;
    } mark_t;

    // One result record
    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] block_address;
        logic [ADDR_W-1:0] top_position;
        logic [ADDR_W-1:0] bytes_in_use;
        logic [LIVE_W-1:0] live_blocks;
    } result_t;

endpackage

### rtl/asa_cfg_regs.sv
// APB-style configuration registers of the allocator: pool_base and pool_size.
// Depends on asa_pkg.
module asa_cfg_regs
    import asa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [ADDR_W-1:0] pool_base,
    output logic [ADDR_W-1:0] pool_size
);

    logic [ADDR_W-1:0] pool_base_reg;
    logic [ADDR_W-1:0] pool_size_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= POOL_BASE_RST;
            pool_size_reg <= POOL_SIZE_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_POOL_BASE) begin
                pool_base_reg <= pwdata;
            end else begin
                pool_size_reg <= pwdata;
            end
        end
    end

    // Read back
    assign prdata    = (paddr[2] == REG_POOL_BASE) ? pool_base_reg : pool_size_reg;
    assign pool_base = pool_base_reg;
    assign pool_size = pool_size_reg;

endmodule

### rtl/asa_mark_store.sv
// Mark stack memory: one write port, one read port with registered data.
// Depends on asa_pkg.
module asa_mark_store
    import asa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  mark_t            wr_mark,
    input  logic [IDX_W-1:0] rd_idx,
    output mark_t            rd_mark
);

    mark_t mem [MAX_BLOCKS];
    mark_t rd_mark_reg;

    // Write and registered read; the core never reads the entry it writes
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_mark;
        end
        rd_mark_reg <= mem[rd_idx];
    end

    assign rd_mark = rd_mark_reg;

endmodule

### rtl/asa_core.sv
// Allocator state and per-item datapath: adjustment, bounds check, push and pop.
// The newest mark is held in a register; the memory prefetches the one below it.
// Depends on asa_pkg and asa_mark_store.
module asa_core
    import asa_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  op_t               op,
    input  logic [ADDR_W-1:0] req_size,
    input  logic [LG_W-1:0]   align_lg,
    input  logic [ADDR_W-1:0] pool_base,
    input  logic [ADDR_W-1:0] pool_size,
    output result_t           result
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic [ADDR_W-1:0] top_reg, top_next;
    logic [ADDR_W-1:0] newest_reg, newest_next;
    logic [ADDR_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    mark_t             tmark_reg, tmark_next;

    logic [ADJ_W-1:0]  hdr_sum;
    logic [ADJ_W-1:0]  align_mask;
    logic [ADJ_W-1:0]  adj;
    logic [ADDR_W+1:0] need;
    logic [ADDR_W-1:0] alloc_addr;
    logic              full, oom;
    logic              mem_we;
    mark_t             mem_wdata, mem_rdata;
    logic [CNT_W-1:0]  rd_cnt;
    status_t           status;
    logic [ADDR_W-1:0] blk_addr;

    // Adjustment: smallest value of at least HEADER_BYTES aligning the top
    // (only the low bits of the top matter, the mask is at most 127)
    assign hdr_sum    = top_reg[ADJ_W-1:0] + ADJ_W'(HEADER_BYTES);
    assign align_mask = ~({ADJ_W{1'b1}} << align_lg);
    assign adj        = ((~hdr_sum + ADJ_W'(1)) & align_mask) + ADJ_W'(HEADER_BYTES);
    assign need       = {2'b00, used_reg} + {2'b00, req_size} + (ADDR_W+2)'(adj);
    assign alloc_addr = top_reg + ADDR_W'(adj);
    assign full       = count_reg >= CNT_W'(MAX_BLOCKS);
    assign oom        = need > {2'b00, pool_size};
    assign mem_wdata  = '{prev: newest_reg, adj: adj};

    // Next state and result for the item in flight
    always_comb begin
        top_next    = top_reg;
        newest_next = newest_reg;
        used_next   = used_reg;
        count_next  = count_reg;
        tmark_next  = tmark_reg;
        mem_we      = 1'b0;
        status      = ST_OK;
        blk_addr    = '0;
        unique case (op)
            OP_ALLOC: begin
                if (full) begin
                    status = ST_FULL;
                end else if (oom) begin
                    status = ST_OOM;
                end else begin
                    blk_addr    = alloc_addr;
                    newest_next = alloc_addr;
                    top_next    = alloc_addr + req_size;
                    used_next   = need[ADDR_W-1:0];
                    count_next  = count_reg + CNT_W'(1);
                    tmark_next  = mem_wdata;
                    mem_we      = fire;
                end
            end
            OP_FREE: begin
                if (count_reg == '0) begin
                    status = ST_EMPTY;
                end else begin
                    used_next   = used_reg - ((top_reg - newest_reg)
                                  + ADDR_W'(tmark_reg.adj));
                    top_next    = newest_reg - ADDR_W'(tmark_reg.adj);
                    newest_next = tmark_reg.prev;
                    count_next  = count_reg - CNT_W'(1);
                    tmark_next  = mem_rdata;
                end
            end
            OP_CLEAR: begin
                top_next   = pool_base;
                used_next  = '0;
                count_next = '0;
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg    <= POOL_BASE_RST;
            newest_reg <= '0;
            used_reg   <= '0;
            count_reg  <= '0;
        end else if (fire) begin
            top_reg    <= top_next;
            newest_reg <= newest_next;
            used_reg   <= used_next;
            count_reg  <= count_next;
        end
    end

    // Newest mark cache, valid only while the stack is not empty
    always_ff @(posedge aclk) begin
        if (fire) begin
            tmark_reg <= tmark_next;
        end
    end

    // Prefetch the entry just below the newest one after this cycle
    assign rd_cnt = (fire ? count_next : count_reg) - CNT_W'(2);

    asa_mark_store #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_mark_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_idx  (count_reg[IDX_W-1:0]),
        .wr_mark (mem_wdata),
        .rd_idx  (rd_cnt[IDX_W-1:0]),
        .rd_mark (mem_rdata)
    );

    assign result = '{
        status:        status,
        block_address: blk_addr,
        top_position:  top_next,
        bytes_in_use:  used_next,
        live_blocks:   LIVE_W'(count_next)
    };

endmodule

### rtl/aligned_stack_allocator_unit.sv
// Aligned stack allocator, top level: input register, core, result register.
// Each item is held in the input register, then in the result register, which drives m_tvalid;
// one item per cycle sustained while m_tready is high, since the add/compare path from the
// input register to the result register is combinational.
// Reset (aresetn low, synchronous): pool_base 0, pool_size 65536, top at 0, stack empty,
// both channels empty. Mark memory is not cleared; only pushed entries are ever used.
// Depends on asa_pkg, asa_cfg_regs and asa_core.
module aligned_stack_allocator_unit
    import asa_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // request_size[31:0], alignment_log2[34:32], zero pad
    input  logic [1:0]   s_tuser,   // operation[1:0]
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // block_address[31:0], top_position[63:32],
                                    // bytes_in_use[95:64], live_blocks[104:96], zero pad
    output logic [1:0]   m_tuser,   // status[1:0]
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic              in_valid_reg;
    op_t               in_op_reg;
    logic [ADDR_W-1:0] in_req_reg;
    logic [LG_W-1:0]   in_lg_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    result_t           core_res;
    logic              fire;
    logic              s_xfer;
    logic [ADDR_W-1:0] pool_base, pool_size;

    asa_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pool_base (pool_base),
        .pool_size (pool_size)
    );

    // Item moves from input register to result register
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_xfer   = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_op_reg  <= op_t'(s_tuser);
            in_req_reg <= s_tdata[31:0];
            in_lg_reg  <= s_tdata[34:32];
        end
    end

    asa_core #(
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .op        (in_op_reg),
        .req_size  (in_req_reg),
        .align_lg  (in_lg_reg),
        .pool_base (pool_base),
        .pool_size (pool_size),
        .result    (core_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {7'd0, out_res_reg.live_blocks, out_res_reg.bytes_in_use,
                       out_res_reg.top_position, out_res_reg.block_address};

endmodule

### sim/aligned_stack_allocator_unit_tb.sv
// Self-checking testbench for aligned_stack_allocator_unit: drives requests on the input
// stream, configures the pool over APB and checks every result against a scoreboard model.
// Depends on asa_pkg and the aligned_stack_allocator_unit RTL.
module aligned_stack_allocator_unit_tb;
    import asa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    // Tracks allocator state and holds the results it should produce, oldest first
    class alloc_scoreboard;
        logic [31:0] pool_base = POOL_BASE_RST;
        logic [31:0] pool_size = POOL_SIZE_RST;
        logic [31:0] top_addr = POOL_BASE_RST;
        logic [31:0] newest = '0;
        logic [31:0] used = '0;
        logic [8:0]  live = '0;
        mark_t       marks[MAX_BLOCKS_DEF];
        result_t     pending_results[$];
        int          errors = 0;
        int          status_hits[4] = '{0, 0, 0, 0};

        function void note_request(op_t op, logic [31:0] req, logic [2:0] lg);
            logic [31:0] mask;
            logic [31:0] adj;
            logic [33:0] need;
            result_t     res;
            res = '0;
            res.status = ST_OK;
            case (op)
                OP_ALLOC: begin
                    mask = (32'd1 << lg) - 32'd1;
                    adj = ((32'd0 - (top_addr + 32'(HEADER_BYTES_DEF))) & mask)
                          + 32'(HEADER_BYTES_DEF);
                    need = 34'(used) + 34'(req) + 34'(adj);
                    if (live >= 9'(MAX_BLOCKS_DEF)) begin
                        res.status = ST_FULL;
                    end else if (need > 34'(pool_size)) begin
                        res.status = ST_OOM;
                    end else begin
                        res.block_address = top_addr + adj;
                        marks[live].prev = newest;
                        marks[live].adj = adj[7:0];
                        newest = res.block_address;
                        top_addr = res.block_address + req;
                        used = need[31:0];
                        live = live + 9'd1;
                    end
                end
                OP_FREE: begin
                    if (live == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        live = live - 9'd1;
                        used = used - ((top_addr - newest) + 32'(marks[live].adj));
                        top_addr = newest - 32'(marks[live].adj);
                        newest = marks[live].prev;
                    end
                end
                OP_CLEAR: begin
                    top_addr = pool_base;
                    used = '0;
                    live = '0;
                end
                default: ;
            endcase
            res.top_position = top_addr;
            res.bytes_in_use = used;
            res.live_blocks = live;
            pending_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d", got.status);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            status_hits[int'(exp.status)]++;
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.block_address !== exp.block_address) begin
                $error("block_address: expected %h, got %h", exp.block_address,
                       got.block_address);
                errors++;
            end
            if (got.top_position !== exp.top_position) begin
                $error("top_position: expected %h, got %h", exp.top_position,
                       got.top_position);
                errors++;
            end
            if (got.bytes_in_use !== exp.bytes_in_use) begin
                $error("bytes_in_use: expected %h, got %h", exp.bytes_in_use,
                       got.bytes_in_use);
                errors++;
            end
            if (got.live_blocks !== exp.live_blocks) begin
                $error("live_blocks: expected %0d, got %0d", exp.live_blocks,
                       got.live_blocks);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;     // request_size[31:0], alignment_log2[34:32], zero pad
    logic [1:0]   s_tuser = OP_NONE; // operation[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;          // block_address[31:0], top_position[63:32],
                                    // bytes_in_use[95:64], live_blocks[104:96], zero pad
    logic [1:0]   m_tuser;          // status[1:0]
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    alloc_scoreboard sb = new;
    int send_gap_pct = 0;
    int ready_stall_pct = 0;
    int cycle_count = 0;
    int pool_settings = 0;

    aligned_stack_allocator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure and checking of each transfer
    always @(posedge aclk) begin
        result_t got;
        m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tuser);
            got.block_address = m_tdata[31:0];
            got.top_position = m_tdata[63:32];
            got.bytes_in_use = m_tdata[95:64];
            got.live_blocks = m_tdata[104:96];
            sb.check_result(got);
        end
    end

    // One request transfer; tvalid stays high after it unless the caller lowers it
    task automatic send_item(op_t op, logic [31:0] req, logic [2:0] lg);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_gap_pct && gap < 12)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'b0, lg, req};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, req, lg);
    endtask

    // Stop the stream and let every outstanding result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic reg_idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_POOL_BASE)
            sb.pool_base = value;
        else
            sb.pool_size = value;
    endtask

    // New pool geometry while idle, then a clear so the top picks up the base
    task automatic set_pool(logic [31:0] base, logic [31:0] size);
        drain();
        apb_write(REG_POOL_BASE, base);
        apb_write(REG_POOL_SIZE, size);
        pool_settings++;
        send_item(OP_CLEAR, $urandom, 3'($urandom));
    endtask

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 32'($urandom_range(0, 64));
        else if (r < 90)
            return 32'($urandom_range(0, 65535));
        return $urandom;
    endfunction

    // Mostly allocate and free, with some clears, unused codes and oversized asks
    task automatic random_mix(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 58)
                send_item(OP_ALLOC, pick_size(), 3'($urandom));
            else if (r < 86)
                send_item(OP_FREE, $urandom, 3'($urandom));
            else if (r < 91)
                send_item(OP_CLEAR, $urandom, 3'($urandom));
            else if (r < 95)
                send_item(OP_NONE, $urandom, 3'($urandom));
            else
                send_item(OP_ALLOC, $urandom | 32'h8000_0000, 3'($urandom));
        end
    endtask

    // Push past a full mark stack, then pop back down
    task automatic fill_then_free(int n_alloc, int n_free);
        repeat (n_alloc)
            send_item(OP_ALLOC, 32'($urandom_range(0, 32)), 3'($urandom));
        repeat (n_free)
            send_item(OP_FREE, $urandom, 3'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: default pool, sender idles lightly, receiver stalls often
        send_gap_pct = 20;
        ready_stall_pct = 51;
        set_pool(POOL_BASE_RST, POOL_SIZE_RST);
        send_item(OP_FREE, 32'd0, 3'd0);            // free on empty stack
        send_item(OP_ALLOC, 32'd0, 3'd0);           // zero-byte block
        send_item(OP_ALLOC, 32'd1, 3'd7);
        send_item(OP_ALLOC, 32'd3, 3'd1);
        send_item(OP_ALLOC, 32'd100, 3'd2);
        send_item(OP_ALLOC, 32'd7, 3'd3);
        send_item(OP_ALLOC, 32'd255, 3'd4);
        send_item(OP_ALLOC, 32'd1000, 3'd5);
        send_item(OP_ALLOC, 32'd17, 3'd6);
        send_item(OP_ALLOC, 32'hFFFF_FFFF, 3'd3);   // out of memory, no wrap
        send_item(OP_ALLOC, 32'd65000, 3'd2);
        send_item(OP_NONE, 32'hFFFF_FFFF, 3'd7);    // unused code
        send_item(OP_FREE, 32'hFFFF_FFFF, 3'd7);
        send_item(OP_FREE, 32'd0, 3'd0);
        send_item(OP_CLEAR, 32'd0, 3'd0);
        send_item(OP_FREE, 32'd0, 3'd0);
        send_item(OP_ALLOC, 32'h0000_FFFF, 3'd5);
        send_item(OP_ALLOC, 32'h8000_0000, 3'd0);
        send_item(OP_FREE, 32'd0, 3'd0);
        send_item(OP_NONE, 32'd0, 3'd0);
        send_item(OP_CLEAR, 32'hAAAA_5555, 3'd5);

        // Huge pool: fill the mark stack
        set_pool(32'h1000_0000, 32'hFFFF_FFFF);
        fill_then_free(258, 40);
        random_mix(120);

        // Pool straddling the top of the address space
        send_gap_pct = 51;
        ready_stall_pct = 20;
        set_pool(32'hFFFF_FF00, 32'h0001_0000);
        random_mix(200);

        // Empty pool at the highest base: every allocate is refused
        set_pool(32'hFFFF_FFFF, 32'd0);
        random_mix(40);

        // Random geometry, no idling at all
        send_gap_pct = 0;
        ready_stall_pct = 0;
        set_pool($urandom, 32'($urandom_range(0, 65535)));
        random_mix(200);

        set_pool(32'd0, 32'hFFFF_FFFF);
        fill_then_free(258, 260);

        drain();
        $display("Checked %0d ok, %0d out-of-memory, %0d stack-full, %0d empty results",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3]);
        $display("over %0d pool settings in %0d cycles", pool_settings, cycle_count);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/asa_pkg.sv
rtl/asa_cfg_regs.sv
rtl/asa_mark_store.sv
rtl/asa_core.sv
rtl/aligned_stack_allocator_unit.sv
sim/aligned_stack_allocator_unit_tb.sv
